// ----- hw/rtl/amount_fifo_partial_drain_unit_macros.svh -----
// Assertion macros used by the amount FIFO datapath.
`ifndef AMOUNT_FIFO_PARTIAL_DRAIN_UNIT_MACROS_SVH
`define AMOUNT_FIFO_PARTIAL_DRAIN_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define AFPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define AFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/afpd_pkg.sv -----
// Shared types, constants and helpers for the amount FIFO.
`timescale 1ns / 1ps
`default_nettype none

package afpd_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int AMOUNT_BITS    = 16;
    localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_BITS  = ((AMOUNT_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = COUNT_BITS + 2 * AMOUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Request kinds carried in tuser
    localparam logic KIND_PRODUCE = 1'b0;
    localparam logic KIND_CONSUME = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRODUCE,
        ST_DRAIN,
        ST_SETTLE,
        ST_RESULT
    } afpd_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic produce;
        logic drain;
        logic load_out;
    } afpd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic head_lt;
        logic head_eq;
    } afpd_stat_t;

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] nxt;
        nxt = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/afpd_ctrl.sv -----
// Sequencing state machine for the amount FIFO.
`timescale 1ns / 1ps
`default_nettype none

module afpd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_kind,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire afpd_pkg::afpd_stat_t stat,
    output afpd_pkg::afpd_cmd_t     cmd
);

    afpd_pkg::afpd_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= afpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            afpd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_kind == afpd_pkg::KIND_CONSUME) ?
                                 afpd_pkg::ST_DRAIN : afpd_pkg::ST_PRODUCE;
                end
            end
            afpd_pkg::ST_PRODUCE:
                state_next = afpd_pkg::ST_SETTLE;
            afpd_pkg::ST_DRAIN:
            begin
                if (stat.empty || stat.head_eq)
                    state_next = afpd_pkg::ST_RESULT;
                else if (!stat.head_lt)
                    state_next = afpd_pkg::ST_SETTLE;  // head was rewritten
            end
            afpd_pkg::ST_SETTLE:
                state_next = afpd_pkg::ST_RESULT;
            afpd_pkg::ST_RESULT:
            begin
                if (out_free)
                    state_next = afpd_pkg::ST_IDLE;
            end
            default:
                state_next = afpd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            afpd_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            afpd_pkg::ST_PRODUCE:
                cmd.produce = 1'b1;
            afpd_pkg::ST_DRAIN:
                cmd.drain = 1'b1;
            afpd_pkg::ST_RESULT:
                cmd.load_out = out_free;
            default:
                cmd = '0;
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/afpd_datapath.sv -----
// Entry store, pointers, drain arithmetic and output register of the amount FIFO.
`timescale 1ns / 1ps
`default_nettype none
`include "amount_fifo_partial_drain_unit_macros.svh"

module afpd_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire afpd_pkg::afpd_cmd_t                  cmd,
    input  wire logic [afpd_pkg::AMOUNT_BITS-1:0]     amount,
    output afpd_pkg::afpd_stat_t                      stat,
    output logic                                      out_status,
    output logic [afpd_pkg::COUNT_BITS-1:0]           out_occupancy,
    output logic [afpd_pkg::AMOUNT_BITS-1:0]          out_oldest,
    output logic [afpd_pkg::AMOUNT_BITS-1:0]          out_unmet
);

    logic [afpd_pkg::AMOUNT_BITS-1:0] mem [afpd_pkg::QUEUE_DEPTH];

    logic [afpd_pkg::AMOUNT_BITS-1:0] head_reg;
    logic [afpd_pkg::AMOUNT_BITS-1:0] demand_reg, demand_next;
    logic [afpd_pkg::AMOUNT_BITS-1:0] unmet_reg, unmet_next;
    logic                             status_reg, status_next;
    logic [afpd_pkg::PTR_BITS-1:0]    oldest_ptr_reg, oldest_ptr_next;
    logic [afpd_pkg::PTR_BITS-1:0]    newest_ptr_reg, newest_ptr_next;
    logic [afpd_pkg::COUNT_BITS-1:0]  count_reg, count_next;

    logic                             wr_en;
    logic [afpd_pkg::PTR_BITS-1:0]    wr_addr;
    logic [afpd_pkg::AMOUNT_BITS-1:0] wr_data;

    logic                             out_status_reg;
    logic [afpd_pkg::COUNT_BITS-1:0]  out_occ_reg;
    logic [afpd_pkg::AMOUNT_BITS-1:0] out_oldest_reg;
    logic [afpd_pkg::AMOUNT_BITS-1:0] out_unmet_reg;

    // assertion terms
    logic                             count_over;
    logic                             ptr_gap;
    logic                             drop_step;
    logic                             empty_drain;

    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (count_reg == afpd_pkg::COUNT_BITS'(afpd_pkg::QUEUE_DEPTH));
    assign stat.head_lt = (head_reg < demand_reg);
    assign stat.head_eq = (head_reg == demand_reg);

    always_comb
    begin
        demand_next     = demand_reg;
        unmet_next      = unmet_reg;
        status_next     = status_reg;
        oldest_ptr_next = oldest_ptr_reg;
        newest_ptr_next = newest_ptr_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_addr         = newest_ptr_reg;
        wr_data         = demand_reg;

        if (cmd.accept)
        begin
            demand_next = amount;
            unmet_next  = '0;
            status_next = 1'b0;
        end

        if (cmd.produce)
        begin
            if (stat.full)
                status_next = 1'b1;
            else
            begin
                wr_en           = 1'b1;
                newest_ptr_next = afpd_pkg::next_slot(newest_ptr_reg);
                count_next      = count_reg + 1'b1;
            end
        end

        // one oldest entry per step
        if (cmd.drain)
        begin
            if (stat.empty)
                unmet_next = demand_reg;
            else if (stat.head_lt || stat.head_eq)
            begin
                demand_next     = demand_reg - head_reg;
                oldest_ptr_next = afpd_pkg::next_slot(oldest_ptr_reg);
                count_next      = count_reg - 1'b1;
            end
            else
            begin
                wr_en   = 1'b1;
                wr_addr = oldest_ptr_reg;
                wr_data = head_reg - demand_reg;
            end
        end
    end

    // entry store: one write port, registered read at the next oldest slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        head_reg <= mem[oldest_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_ptr_reg <= '0;
            newest_ptr_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            oldest_ptr_reg <= oldest_ptr_next;
            newest_ptr_reg <= newest_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        demand_reg <= demand_next;
        unmet_reg  <= unmet_next;
        status_reg <= status_next;
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_occ_reg    <= count_reg;
            out_oldest_reg <= stat.empty ? '0 : head_reg;
            out_unmet_reg  <= unmet_reg;
        end
    end

    assign out_status    = out_status_reg;
    assign out_occupancy = out_occ_reg;
    assign out_oldest    = out_oldest_reg;
    assign out_unmet     = out_unmet_reg;

    assign count_over  = (count_reg > afpd_pkg::COUNT_BITS'(afpd_pkg::QUEUE_DEPTH));
    assign ptr_gap     = (oldest_ptr_reg != newest_ptr_reg);
    assign drop_step   = cmd.produce && stat.full;
    assign empty_drain = cmd.drain && stat.empty;

    `AFPD_ASSERT_SAME(a_count_bound, 1'b1, !count_over, "entry count above queue depth")
    `AFPD_ASSERT_SAME(a_ptr_match, stat.empty || stat.full, !ptr_gap, "pointer mismatch")
    `AFPD_ASSERT_NEXT(a_drop_holds, drop_step, status_reg && $stable(count_reg), "bad drop")
    `AFPD_ASSERT_NEXT(a_empty_unmet, empty_drain, unmet_reg == $past(demand_reg), "unmet lost")
    `AFPD_ASSERT_NEXT(a_empty_stays, empty_drain, stat.empty, "empty queue changed")

endmodule

`default_nettype wire

// ----- hw/rtl/amount_fifo_partial_drain_unit.sv -----
// Top level of the amount FIFO with partial drain.
// A produce request passes PRODUCE, SETTLE and RESULT; a consume request stays in
// DRAIN, one oldest entry per step, then goes to RESULT, via SETTLE after a head rewrite.
// Requests are served one at a time; the drain loop walks the entry store through its
// single registered read port. The next request is taken once the result is registered.
// Reset (rst_n low, asynchronous): pointers, count, state and output valid clear;
// the entry store keeps its contents and is only read where it was written.
`timescale 1ns / 1ps
`default_nettype none

module amount_fifo_partial_drain_unit (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // request channel
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  wire logic [afpd_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,  // amount, zero pad
    input  wire logic                                    s_axis_tuser,  // kind
    // result channel
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    output logic [afpd_pkg::OUT_TDATA_BITS-1:0]          m_axis_tdata,  // occupancy,
                                                                        // oldest_amount,
                                                                        // unmet_demand, pad
    output logic                                         m_axis_tuser   // status
);

    afpd_pkg::afpd_cmd_t              cmd;
    afpd_pkg::afpd_stat_t             stat;
    logic [afpd_pkg::COUNT_BITS-1:0]  occupancy;
    logic [afpd_pkg::AMOUNT_BITS-1:0] oldest_amount;
    logic [afpd_pkg::AMOUNT_BITS-1:0] unmet_demand;

    // Controller: accepts a request in IDLE, walks produce or drain steps,
    // then loads the output register when it is free.
    afpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: ring of amounts, head compare/subtract, result register.
    afpd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .amount        (s_axis_tdata[afpd_pkg::AMOUNT_BITS-1:0]),
        .stat          (stat),
        .out_status    (m_axis_tuser),
        .out_occupancy (occupancy),
        .out_oldest    (oldest_amount),
        .out_unmet     (unmet_demand)
    );

    // Result fields packed from bit 0 up, zero filled to a whole byte.
    assign m_axis_tdata = afpd_pkg::OUT_TDATA_BITS'({unmet_demand, oldest_amount, occupancy});

endmodule

`default_nettype wire

// ----- tb/afpd_drain_checker.sv -----
// Scoreboard for the amount FIFO: tracks the queue, predicts each result, compares.
`timescale 1ns / 1ps

module afpd_drain_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [afpd_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,   // amount, pad
    input  logic                                s_axis_tuser,   // kind
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [afpd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,   // occupancy, oldest_amount,
                                                                // unmet_demand, pad
    input  logic                                m_axis_tuser,   // status
    output int                                  mismatch_count,
    output int                                  reports_outstanding
);

    import afpd_pkg::*;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic                   status;
        logic [COUNT_BITS-1:0]  occupancy;
        logic [AMOUNT_BITS-1:0] oldest_amount;
        logic [AMOUNT_BITS-1:0] unmet_demand;
    } drain_report_t;

    // shadow of the queue
    logic [AMOUNT_BITS-1:0] held_amounts [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    oldest_idx;
    logic [PTR_BITS-1:0]    newest_idx;
    logic [COUNT_BITS-1:0]  held_count;

    drain_report_t expected_reports [$];

    function automatic logic [PTR_BITS-1:0] bump_slot(input logic [PTR_BITS-1:0] idx);
        if (int'(idx) + 1 >= QUEUE_DEPTH)
            return '0;
        return idx + 1'b1;
    endfunction

    // append or drain, then report the queue as it stands afterwards
    task automatic apply_request(input logic kind, input logic [AMOUNT_BITS-1:0] amount,
                                 output drain_report_t rpt);
        logic [AMOUNT_BITS-1:0] demand;
        logic                   draining;
        rpt    = '0;
        demand = amount;
        if (kind == KIND_PRODUCE)
        begin
            if (int'(held_count) >= QUEUE_DEPTH)
                rpt.status = STATUS_DROPPED;
            else
            begin
                held_amounts[newest_idx] = amount;
                newest_idx = bump_slot(newest_idx);
                held_count = held_count + 1'b1;
            end
        end
        else
        begin
            rpt.status = STATUS_DONE;
            draining   = 1'b1;
            while (draining)
            begin
                if (held_count == '0)
                begin
                    rpt.unmet_demand = demand;
                    draining = 1'b0;
                end
                else if (held_amounts[oldest_idx] < demand)
                begin
                    demand     = demand - held_amounts[oldest_idx];
                    oldest_idx = bump_slot(oldest_idx);
                    held_count = held_count - 1'b1;
                end
                else if (held_amounts[oldest_idx] == demand)
                begin
                    oldest_idx = bump_slot(oldest_idx);
                    held_count = held_count - 1'b1;
                    draining   = 1'b0;
                end
                else
                begin
                    held_amounts[oldest_idx] = held_amounts[oldest_idx] - demand;
                    draining = 1'b0;
                end
            end
        end
        rpt.occupancy     = held_count;
        rpt.oldest_amount = (held_count == '0) ? '0 : held_amounts[oldest_idx];
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drain_report_t predicted;
        drain_report_t want;
        if (!rst_n)
        begin
            oldest_idx          = '0;
            newest_idx          = '0;
            held_count          = '0;
            mismatch_count      = 0;
            reports_outstanding = 0;
            expected_reports.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(s_axis_tuser, s_axis_tdata[AMOUNT_BITS-1:0], predicted);
                expected_reports.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("occupancy", want.occupancy,
                                m_axis_tdata[COUNT_BITS-1:0]);
                    check_field("oldest_amount", want.oldest_amount,
                                m_axis_tdata[COUNT_BITS +: AMOUNT_BITS]);
                    check_field("unmet_demand", want.unmet_demand,
                                m_axis_tdata[COUNT_BITS+AMOUNT_BITS +: AMOUNT_BITS]);
                end
            end
            reports_outstanding = expected_reports.size();
        end
    end

endmodule

// ----- tb/amount_fifo_partial_drain_unit_test.sv -----
// Top of the amount FIFO regression: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module amount_fifo_partial_drain_unit_test;

    import afpd_pkg::*;

    // Random part size; the idle mix changes every PHASE_LEN requests.
    localparam int RANDOM_REQUESTS = 1050;
    localparam int PHASE_LEN       = 350;
    // Receiver hold-off at the start of the no-idle phase. The block serves one
    // request at a time, so it stops taking requests once a result waits on the output.
    localparam int HOLD_CYCLES     = 400;
    // A consume walks at most QUEUE_DEPTH entries.
    localparam int DRAIN_TAIL      = QUEUE_DEPTH + 8;
    // Longest legal quiet stretch is the hold-off plus one drain; allow plenty more.
    localparam int STALL_LIMIT     = 2000;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;   // amount, pad
    logic                      s_axis_tuser;   // kind
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // occupancy, oldest_amount, unmet_demand, pad
    logic                      m_axis_tuser;   // status

    int mismatch_count;
    int reports_outstanding;

    // Idle odds in percent, set by the stimulus process per phase.
    int sender_idle_pct;
    int receiver_idle_pct;
    int quiet_cycles;

    amount_fifo_partial_drain_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    afpd_drain_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .mismatch_count      (mismatch_count),
        .reports_outstanding (reports_outstanding)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: counts cycles in which neither channel moves a request or result.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("amount_fifo_partial_drain_unit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side. Random back-pressure per cycle at the current odds; when the
    // no-idle phase begins, one long hold-off first so the block backs up.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && rst_n && sender_idle_pct == 0 && receiver_idle_pct == 0)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Present one request, after a random gap, and hold it until the block takes it.
    // Called right after a rising edge; returns at the edge of acceptance.
    task automatic offer_request(input logic kind, input logic [AMOUNT_BITS-1:0] amount);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_TDATA_BITS'(amount);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Random request. Produce odds swing between fill and drain spells so the
    // queue keeps hitting full (dropped produces) and empty (unmet demand).
    // Most amounts are multiples of 16 in a narrow band, so demands often match
    // the head or a run of entries exactly and multi-entry drains are common.
    task automatic random_request(input int produce_pct);
        logic                   kind;
        logic [AMOUNT_BITS-1:0] amount;
        int unsigned            roll;
        kind = ($urandom_range(0, 99) < produce_pct) ? KIND_PRODUCE : KIND_CONSUME;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            amount = '1;
        else if (roll == 1)
            amount = '0;
        else if (roll < 5)
            amount = AMOUNT_BITS'($urandom);
        else if (roll < 12)
            amount = AMOUNT_BITS'($urandom_range(0, 16) * 16);
        else
            amount = AMOUNT_BITS'($urandom_range(0, 300));
        offer_request(kind, amount);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = KIND_PRODUCE;
        m_axis_tready     = 1'b0;
        quiet_cycles      = 0;
        sender_idle_pct   = 26;
        receiver_idle_pct = 61;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue consumes report the whole demand as unmet
        offer_request(KIND_CONSUME, '0);
        offer_request(KIND_CONSUME, '1);
        // zero demand removes a zero head ...
        offer_request(KIND_PRODUCE, '0);
        offer_request(KIND_CONSUME, '0);
        // ... but leaves a nonzero head alone
        offer_request(KIND_PRODUCE, AMOUNT_BITS'(10));
        offer_request(KIND_CONSUME, '0);
        // smaller head removed, next one reduced; then an exact match empties it
        offer_request(KIND_PRODUCE, AMOUNT_BITS'(20));
        offer_request(KIND_CONSUME, AMOUNT_BITS'(15));
        offer_request(KIND_CONSUME, AMOUNT_BITS'(15));
        // fill to the brim, one produce too many is dropped
        for (int i = 0; i < QUEUE_DEPTH; i++)
            offer_request(KIND_PRODUCE, (i == 0) ? '1 : AMOUNT_BITS'(i * 16));
        offer_request(KIND_PRODUCE, AMOUNT_BITS'(16'hA5A5));
        // full-scale demand against a full-scale head: exact match
        offer_request(KIND_CONSUME, '1);

        // Random: three idle phases, the last one free-running after the hold-off
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == PHASE_LEN)
            begin
                sender_idle_pct   = 61;
                receiver_idle_pct = 26;
            end
            else if (n == 2 * PHASE_LEN)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            random_request(((n / 40) % 2 == 0) ? 75 : 35);
        end
        s_axis_tvalid <= 1'b0;

        // let every outstanding result drain, then a little longer for stragglers
        while (reports_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_count == 0 && reports_outstanding == 0)
            $display("amount_fifo_partial_drain_unit regression: pass");
        else
            $display("amount_fifo_partial_drain_unit regression: fail");
        $finish;
    end

endmodule

// ----- amount_fifo_partial_drain_unit.f -----
+incdir+hw/rtl
hw/rtl/afpd_pkg.sv
hw/rtl/afpd_ctrl.sv
hw/rtl/afpd_datapath.sv
hw/rtl/amount_fifo_partial_drain_unit.sv
tb/afpd_drain_checker.sv
tb/amount_fifo_partial_drain_unit_test.sv
